/* src/swtq_pkg.sv */
// Package for the sorted wake-up timer queue.
// Status codes, field widths and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swtq_pkg;

    localparam int TIME_W   = 63;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 6;

    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED  = 3'd0,
        ST_IDLE    = 3'd1,
        ST_FULL    = 3'd2,
        ST_WOKEN   = 3'd3,
        ST_NONE    = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic insert;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        logic op;
        logic is_idle;
        logic full;
        logic head_due;
        logic next_due;
    } t_dp_stat;

endpackage

`default_nettype wire

/* src/sorted_wakeup_timer_queue.sv */
// Sorted wake-up timer queue: a sleep request is decoded after accept and gives a
// single result; a tick releases n due entries, one per cycle, from the head of the
// slot shift line (n = 0 gives one nothing-due result).
// busy drops with the final result; the next request is taken at the edge ending it.
// Synchronous active-low reset empties the queue and clears the idle id to 0.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module sorted_wakeup_timer_queue import swtq_pkg::*; #(
    parameter int QUEUE_SLOTS = 16,
    parameter int ID_BITS     = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_start,
    input  wire logic               i_operation,
    input  wire logic [ID_BITS-1:0] i_task_id,
    input  wire logic [TIME_W-1:0]  i_time_value,
    output logic                    o_busy,
    output logic                    o_result_valid,
    output logic [STATUS_W-1:0]     o_status,
    output logic [ID_BITS-1:0]      o_woken_id,
    output logic                    o_last_result
);

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [ID_BITS-1:0] w_head_id;

    swtq_ctrl #(
        .ID_BITS(ID_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_stat         (w_stat),
        .i_head_id      (w_head_id),
        .o_cmd          (w_cmd),
        .o_busy         (o_busy),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_woken_id     (o_woken_id),
        .o_last_result  (o_last_result)
    );

    swtq_datapath #(
        .QUEUE_SLOTS(QUEUE_SLOTS),
        .ID_BITS    (ID_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_operation  (i_operation),
        .i_task_id    (i_task_id),
        .i_time_value (i_time_value),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_head_id    (w_head_id)
    );

endmodule

`default_nettype wire

/* src/swtq_datapath.sv */
// Datapath: request latch, idle id register and the sorted slot array.
// Slots form a shift line: insert shifts right from the insert point, pop shifts left.
// Depends on swtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swtq_datapath import swtq_pkg::*; #(
    parameter int QUEUE_SLOTS = 16,
    parameter int ID_BITS     = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_operation,
    input  wire logic [ID_BITS-1:0] i_task_id,
    input  wire logic [TIME_W-1:0]  i_time_value,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    output logic [ID_BITS-1:0]      o_head_id
);

    localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);

    logic [CFG_W-1:0]   r_idle;
    logic               r_op;
    logic [ID_BITS-1:0] r_id;
    logic [TIME_W-1:0]  r_t;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    logic [TIME_W-1:0]  r_wake [QUEUE_SLOTS];
    logic [ID_BITS-1:0] r_ids  [QUEUE_SLOTS];
    logic [QUEUE_SLOTS-1:0] w_le;
    logic [ID_BITS-1:0] w_idle_ext;
    logic               w_next_due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle  <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_idle <= i_cfg_data;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_id <= i_task_id;
            r_t  <= i_time_value;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    for (genvar i = 0; i < QUEUE_SLOTS; i++) begin : g_slot
        logic w_prev_le;
        assign w_le[i] = (CNT_W'(i) < r_count) && (r_wake[i] <= r_t);
        if (i == 0) begin : g_first
            assign w_prev_le = 1'b1;
        end else begin : g_rest
            assign w_prev_le = w_le[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.insert && !w_le[i]) begin
                if (w_prev_le) begin
                    r_wake[i] <= r_t;
                    r_ids[i]  <= r_id;
                end else if (i > 0) begin
                    r_wake[i] <= r_wake[(i > 0) ? i - 1 : 0];
                    r_ids[i]  <= r_ids[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.pop && (i < QUEUE_SLOTS - 1)) begin
                r_wake[i] <= r_wake[(i < QUEUE_SLOTS - 1) ? i + 1 : i];
                r_ids[i]  <= r_ids[(i < QUEUE_SLOTS - 1) ? i + 1 : i];
            end
        end
    end

    if (QUEUE_SLOTS > 1) begin : g_next
        assign w_next_due = w_le[1];
    end else begin : g_no_next
        assign w_next_due = 1'b0;
    end

    assign w_idle_ext = ID_BITS'(r_idle);

    assign o_stat.op       = r_op;
    assign o_stat.is_idle  = (r_id == w_idle_ext);
    assign o_stat.full     = (r_count == CNT_W'(QUEUE_SLOTS));
    assign o_stat.head_due = w_le[0];
    assign o_stat.next_due = w_next_due;
    assign o_head_id       = r_ids[0];

endmodule

`default_nettype wire

/* src/swtq_ctrl.sv */
// Controller: sequences one request at a time and drives the result strobe.
// Issues load/insert/pop commands to swtq_datapath. Depends on swtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swtq_ctrl import swtq_pkg::*; #(
    parameter int ID_BITS = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_dp_stat           i_stat,
    input  wire logic [ID_BITS-1:0] i_head_id,
    output t_dp_cmd                 o_cmd,
    output logic                    o_busy,
    output logic                    o_result_valid,
    output logic [STATUS_W-1:0]     o_status,
    output logic [ID_BITS-1:0]      o_woken_id,
    output logic                    o_last_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_RELEASE
    } t_state;

    t_state             r_state;
    logic               r_busy;
    logic               r_valid;
    t_status            r_status;
    logic [ID_BITS-1:0] r_woken;
    logic               r_last;

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_start && !r_busy;
        o_cmd.insert = (r_state == S_DECODE) && (i_stat.op == OP_SLEEP)
                       && !i_stat.is_idle && !i_stat.full;
        o_cmd.pop    = (((r_state == S_DECODE) && (i_stat.op == OP_TICK))
                       || (r_state == S_RELEASE)) && i_stat.head_due;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_valid  <= 1'b0;
            r_status <= ST_QUEUED;
            r_woken  <= '0;
            r_last   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start && !r_busy) begin
                        r_state <= S_DECODE;
                        r_busy  <= 1'b1;
                    end
                end
                S_DECODE, S_RELEASE: begin
                    r_valid <= 1'b1;
                    if ((r_state == S_DECODE) && (i_stat.op == OP_SLEEP)) begin
                        r_woken <= '0;
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                        if (i_stat.is_idle) begin
                            r_status <= ST_IDLE;
                        end else if (i_stat.full) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_QUEUED;
                        end
                    end else if (!i_stat.head_due) begin
                        r_status <= ST_NONE;
                        r_woken  <= '0;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                        r_busy   <= 1'b0;
                    end else begin
                        r_status <= ST_WOKEN;
                        r_woken  <= i_head_id;
                        r_last   <= !i_stat.next_due;
                        if (i_stat.next_due) begin
                            r_state <= S_RELEASE;
                        end else begin
                            r_state <= S_IDLE;
                            r_busy  <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy         = r_busy;
    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_woken_id     = r_woken;
    assign o_last_result  = r_last;

    a_mid_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |-> r_busy)
        else $error("non-final result while not busy");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_last |-> !r_busy)
        else $error("still busy after final result");

    a_non_woken_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_status != ST_WOKEN) |-> r_last && (r_woken == '0))
        else $error("single result malformed");

    a_no_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !r_busy |=> !r_valid && r_busy)
        else $error("result in decode cycle");

endmodule

`default_nettype wire

/* sim/tb_sorted_wakeup_timer_queue.sv */
// Self-checking testbench for sorted_wakeup_timer_queue: directed and random sleep/tick
// requests, each checked against a cycle-free model of the sorted queue in a scoreboard.
// Depends on swtq_pkg and the sorted_wakeup_timer_queue RTL.
`timescale 1ns / 1ps

class timer_queue_scoreboard #(int SLOTS = 16, int ID_W = 6);
    typedef struct packed {
        swtq_pkg::t_status status;
        logic [ID_W-1:0]   woken_id;
        logic              last;
    } t_wake_result;

    logic [swtq_pkg::TIME_W-1:0] wake_at [SLOTS];
    logic [ID_W-1:0]             sleeper [SLOTS];
    int                          count;
    logic [ID_W-1:0]             idle_id;
    t_wake_result                pending_results[$];

    int failures;
    int requests;
    int results;
    int n_woken, n_queued, n_full, n_idle, n_none;

    function new();
        count    = 0;
        idle_id  = '0;
        failures = 0;
        requests = 0;
        results  = 0;
        n_woken  = 0;
        n_queued = 0;
        n_full   = 0;
        n_idle   = 0;
        n_none   = 0;
    endfunction

    function void set_idle(logic [ID_W-1:0] v);
        idle_id = v;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function void add_expected(swtq_pkg::t_status st, logic [ID_W-1:0] id, logic last);
        t_wake_result r;
        r.status   = st;
        r.woken_id = id;
        r.last     = last;
        pending_results.push_back(r);
    endfunction

    function void note_request(logic op, logic [ID_W-1:0] id,
                               logic [swtq_pkg::TIME_W-1:0] t);
        int pos;
        int due;
        int k;
        requests++;
        if (op == swtq_pkg::OP_SLEEP) begin
            if (id == idle_id) begin
                add_expected(swtq_pkg::ST_IDLE, '0, 1'b1);
            end else if (count >= SLOTS) begin
                add_expected(swtq_pkg::ST_FULL, '0, 1'b1);
            end else begin
                pos = 0;
                while (pos < count && wake_at[pos] <= t) pos++;
                for (k = count; k > pos; k--) begin
                    wake_at[k] = wake_at[k-1];
                    sleeper[k] = sleeper[k-1];
                end
                wake_at[pos] = t;
                sleeper[pos] = id;
                count++;
                add_expected(swtq_pkg::ST_QUEUED, '0, 1'b1);
            end
        end else begin
            due = 0;
            while (due < count && wake_at[due] <= t) due++;
            if (due == 0) begin
                add_expected(swtq_pkg::ST_NONE, '0, 1'b1);
            end else begin
                for (k = 0; k < due; k++)
                    add_expected(swtq_pkg::ST_WOKEN, sleeper[k], (k == due - 1));
                for (k = 0; k < count - due; k++) begin
                    wake_at[k] = wake_at[k+due];
                    sleeper[k] = sleeper[k+due];
                end
                count -= due;
            end
        end
    endfunction

    function void check_result(logic [swtq_pkg::STATUS_W-1:0] status, logic [ID_W-1:0] id,
                               logic last);
        t_wake_result exp_r;
        results++;
        if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: status %0d id %0d last %0d", status, id, last);
            return;
        end
        exp_r = pending_results.pop_front();
        case (exp_r.status)
            swtq_pkg::ST_WOKEN:  n_woken++;
            swtq_pkg::ST_QUEUED: n_queued++;
            swtq_pkg::ST_FULL:   n_full++;
            swtq_pkg::ST_IDLE:   n_idle++;
            default:             n_none++;
        endcase
        if (status !== exp_r.status || id !== exp_r.woken_id || last !== exp_r.last) begin
            failures++;
            if (failures <= 10)
                $display("mismatch: expected status %0d id %0d last %0d, got %0d %0d %0d",
                         exp_r.status, exp_r.woken_id, exp_r.last, status, id, last);
        end
    endfunction
endclass

module tb_sorted_wakeup_timer_queue;
    import swtq_pkg::*;

    localparam int QUEUE_SLOTS = 16;
    localparam int ID_BITS     = 6;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data   = '0;
    logic               i_start      = 1'b0;
    logic               i_operation  = 1'b0;
    logic [ID_BITS-1:0] i_task_id    = '0;
    logic [TIME_W-1:0]  i_time_value = '0;
    logic               o_busy;
    logic               o_result_valid;
    logic [STATUS_W-1:0] o_status;
    logic [ID_BITS-1:0] o_woken_id;
    logic               o_last_result;

    logic [TIME_W-1:0]  clock_now;

    timer_queue_scoreboard #(QUEUE_SLOTS, ID_BITS) sb;

    sorted_wakeup_timer_queue #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .ID_BITS     (ID_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .i_operation    (i_operation),
        .i_task_id      (i_task_id),
        .i_time_value   (i_time_value),
        .o_busy         (o_busy),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_woken_id     (o_woken_id),
        .o_last_result  (o_last_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid)
                sb.check_result(o_status, o_woken_id, o_last_result);
            if (i_start && !o_busy)
                sb.note_request(i_operation, i_task_id, i_time_value);
        end
    end

    task automatic send_request(logic op, logic [ID_BITS-1:0] id, logic [TIME_W-1:0] t);
        i_start      <= 1'b1;
        i_operation  <= op;
        i_task_id    <= id;
        i_time_value <= t;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_idle_id(logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_idle(v);
    endtask

    task automatic run_random(int n, int idle_pct);
        int i;
        int gap;
        int tick_pct;
        int r;
        logic [ID_BITS-1:0] id;
        logic [TIME_W-1:0]  t;
        for (i = 0; i < n; i++) begin
            gap = 0;
            while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // alternate drain-heavy and fill-heavy stretches so the queue reaches full
            tick_pct = ((i / 15) % 2) ? 10 : 40;
            r = $urandom_range(99);
            id = ID_BITS'($urandom);
            if (r < tick_pct) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    t = TIME_MAX;
                end else if (r < 20) begin
                    t = TIME_W'({$urandom, $urandom});
                end else begin
                    clock_now = clock_now + TIME_W'($urandom_range(15));
                    t = clock_now;
                end
                send_request(OP_TICK, id, t);
            end else begin
                if ($urandom_range(99) < 12)
                    id = sb.idle_id;
                if ($urandom_range(99) < 8)
                    t = TIME_W'({$urandom, $urandom});
                else
                    t = clock_now + TIME_W'($urandom_range(40));
                send_request(OP_SLEEP, id, t);
            end
        end
    endtask

    initial begin
        int k;
        sb = new();
        clock_now = TIME_W'($urandom_range(1000));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle id is 0 from reset
        send_request(OP_TICK,  6'd0,  '0);           // empty queue, nothing due
        send_request(OP_SLEEP, 6'd0,  TIME_W'(5));   // idle id ignored
        send_request(OP_SLEEP, 6'd63, TIME_MAX);
        send_request(OP_SLEEP, 6'd1,  '0);
        send_request(OP_TICK,  6'd63, '0);           // wakes id 1 only
        send_request(OP_TICK,  6'd0,  '0);           // nothing due
        for (k = 0; k < 15; k++)                     // equal ticks keep arrival order
            send_request(OP_SLEEP, ID_BITS'(k + 2), TIME_W'((k % 3) * 10));
        send_request(OP_SLEEP, 6'd40, TIME_W'(3));   // full
        send_request(OP_SLEEP, 6'd0,  TIME_W'(3));   // idle check wins over full
        send_request(OP_TICK,  6'd0,  TIME_MAX);     // releases all slots

        set_idle_id(6'd63);
        run_random(50, 24);
        set_idle_id(CFG_W'($urandom_range(62, 1)));
        run_random(50, 70);
        set_idle_id(6'd0);
        run_random(50, 0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d requests and %0d results over three idle id settings.",
                 sb.requests, sb.results);
        $display("Results: %0d woken, %0d queued, %0d full, %0d idle, %0d nothing due.",
                 sb.n_woken, sb.n_queued, sb.n_full, sb.n_idle, sb.n_none);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end
endmodule
